FILE: rtl/ihex_pkg.sv
// Package for the HEX record decoder: token, phase and status types, and field codes.
// No dependencies. Imported by every module under rtl.

package ihex_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CHAR_COLON = 8'h3a;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CHECKSUM = 2'd1;
	localparam logic [1:0] ST_BAD_CHAR = 2'd2;
	localparam logic [1:0] ST_BAD_TYPE = 2'd3;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_ESA  = 8'h02;
	localparam logic [7:0] REC_SSA  = 8'h03;
	localparam logic [7:0] REC_ELA  = 8'h04;
	localparam logic [7:0] REC_SLA  = 8'h05;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_COUNT,
		PH_ADDR,
		PH_TYPE,
		PH_DATA,
		PH_CHECK
	} phase_t;

	typedef enum logic [1:0] {
		TK_COLON,
		TK_HEX,
		TK_BAD
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [3:0]  nib;
	} tok_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] byte_offset;
		logic [1:0]  record_status;
		logic [7:0]  type_code;
		logic [7:0]  byte_count;
		logic [15:0] record_address;
		logic [15:0] upper_linear;
		logic [15:0] segment_base;
		logic [31:0] start_address;
	} result_t;

endpackage

FILE: rtl/ihex_front.sv
// Front end: takes one character a beat and classifies it into a token.
// Depends on ihex_pkg; feeds ihex_queue.

module ihex_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	output logic             tok_valid,
	input  logic             tok_ready,
	output ihex_pkg::tok_t   tok
);
	import ihex_pkg::*;

	function automatic tok_t classify(input logic [7:0] c);
		tok_t t;
		t.kind = TK_BAD;
		t.nib  = 4'd0;
		if (c == CHAR_COLON) begin
			t.kind = TK_COLON;
		end else if (c inside {[8'h30:8'h39]}) begin
			t.kind = TK_HEX;
			t.nib  = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			t.kind = TK_HEX;
			t.nib  = 4'(c[3:0] + 4'd9);
		end
		return t;
	endfunction

	logic vld_s1;
	tok_t tok_s1;

	assign s_tready  = !vld_s1 || tok_ready;
	assign tok_valid = vld_s1;
	assign tok       = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tok_s1 <= classify(s_tdata);
		end
	end

endmodule

FILE: rtl/ihex_queue.sv
// Short token queue between the classifier and the record parser.
// Depends on ihex_pkg.

module ihex_queue #(
	parameter int DEPTH = ihex_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  ihex_pkg::tok_t   wr_tok,
	output logic             rd_valid,
	input  logic             rd_ready,
	output ihex_pkg::tok_t   rd_tok
);
	import ihex_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tok_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign wr_ready = cnt_q != CW'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_tok   = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
		else $error("queue count missed a write");

endmodule

FILE: rtl/ihex_back.sv
// Back end: record parser state machine, address registers and output register.
// Depends on ihex_pkg; takes tokens from ihex_queue.

module ihex_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	output logic               tok_ready,
	input  ihex_pkg::tok_t     tok,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic               m_kind,
	output ihex_pkg::result_t  m_res
);
	import ihex_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  hi_q, hi_d;
	logic        nib_q, nib_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  idx_q, idx_d;
	logic [15:0] addr_q, addr_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  sum_q, sum_d;
	logic [31:0] pend_q, pend_d;
	logic        err_q, err_d;
	logic [15:0] ul_q, ul_d;
	logic [15:0] seg_q, seg_d;
	logic [31:0] start_q, start_d;

	logic        out_vld_q;
	logic        out_kind_q;
	result_t     out_res_q;

	logic        pop;
	logic        take;
	logic [7:0]  byte_v;
	logic [7:0]  idx_inc;
	logic        emit;
	logic        emit_kind;
	result_t     res;
	logic [1:0]  status;

	assign tok_ready = !out_vld_q || m_tready;
	assign pop       = tok_valid && tok_ready;
	assign take      = pop && tok.kind == TK_HEX && phase_q != PH_IDLE && nib_q;
	assign byte_v    = {hi_q, tok.nib};
	assign idx_inc   = 8'(idx_q + 8'd1);

	always_comb begin
		phase_d = phase_q;
		if (pop) begin
			if (tok.kind == TK_COLON) begin
				phase_d = PH_COUNT;
			end else if (take) begin
				case (phase_q)
					PH_COUNT: phase_d = PH_ADDR;
					PH_ADDR:  phase_d = idx_q[0] ? PH_TYPE : PH_ADDR;
					PH_TYPE:  phase_d = (count_q != 8'd0) ? PH_DATA : PH_CHECK;
					PH_DATA:  phase_d = (idx_inc >= count_q) ? PH_CHECK : PH_DATA;
					PH_CHECK: phase_d = PH_IDLE;
					default:  phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		hi_d      = hi_q;
		nib_d     = nib_q;
		count_d   = count_q;
		idx_d     = idx_q;
		addr_d    = addr_q;
		type_d    = type_q;
		sum_d     = sum_q;
		pend_d    = pend_q;
		err_d     = err_q;
		ul_d      = ul_q;
		seg_d     = seg_q;
		start_d   = start_q;
		emit      = 1'b0;
		emit_kind = KIND_DATA;
		status    = ST_OK;
		if (err_q) begin
			status = ST_BAD_CHAR;
		end else if (8'(sum_q + byte_v) != 8'd0) begin
			status = ST_CHECKSUM;
		end else if (type_q > REC_SLA) begin
			status = ST_BAD_TYPE;
		end
		res.data_byte = 8'd0;
		res.byte_offset = 16'd0;
		res.record_status = ST_OK;
		if (pop && tok.kind == TK_COLON) begin
			hi_d    = 4'd0;
			nib_d   = 1'b0;
			count_d = 8'd0;
			idx_d   = 8'd0;
			addr_d  = 16'd0;
			type_d  = 8'd0;
			sum_d   = 8'd0;
			pend_d  = 32'd0;
			err_d   = 1'b0;
		end else if (pop && phase_q != PH_IDLE) begin
			if (tok.kind != TK_HEX) begin
				err_d = 1'b1;
			end else if (!nib_q) begin
				hi_d  = tok.nib;
				nib_d = 1'b1;
			end else begin
				nib_d = 1'b0;
				sum_d = 8'(sum_q + byte_v);
				case (phase_q)
					PH_COUNT: begin
						count_d = byte_v;
						idx_d   = 8'd0;
					end
					PH_ADDR: begin
						addr_d = {addr_q[7:0], byte_v};
						idx_d  = idx_q[0] ? 8'd0 : idx_inc;
					end
					PH_TYPE: begin
						type_d = byte_v;
						idx_d  = 8'd0;
					end
					PH_DATA: begin
						pend_d = {pend_q[23:0], byte_v};
						idx_d  = idx_inc;
						if (type_q == REC_DATA) begin
							emit            = 1'b1;
							res.data_byte   = byte_v;
							res.byte_offset = 16'(addr_q + {8'd0, idx_q});
						end
					end
					PH_CHECK: begin
						emit              = 1'b1;
						emit_kind         = KIND_END;
						res.record_status = status;
						if (status == ST_OK) begin
							if (type_q == REC_ESA) begin
								seg_d = pend_q[15:0];
							end else if (type_q == REC_ELA) begin
								ul_d = pend_q[15:0];
							end else if (type_q == REC_SSA || type_q == REC_SLA) begin
								start_d = pend_q;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
		res.type_code      = type_q;
		res.byte_count     = count_q;
		res.record_address = addr_q;
		res.upper_linear   = ul_d;
		res.segment_base   = seg_d;
		res.start_address  = start_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hi_q      <= 4'd0;
			nib_q     <= 1'b0;
			count_q   <= 8'd0;
			idx_q     <= 8'd0;
			addr_q    <= 16'd0;
			type_q    <= 8'd0;
			sum_q     <= 8'd0;
			pend_q    <= 32'd0;
			err_q     <= 1'b0;
			ul_q      <= 16'd0;
			seg_q     <= 16'd0;
			start_q   <= 32'd0;
			out_vld_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hi_q    <= hi_d;
			nib_q   <= nib_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			addr_q  <= addr_d;
			type_q  <= type_d;
			sum_q   <= sum_d;
			pend_q  <= pend_d;
			err_q   <= err_d;
			ul_q    <= ul_d;
			seg_q   <= seg_d;
			start_q <= start_d;
			if (pop) begin
				out_vld_q <= emit;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_kind_q <= emit_kind;
			out_res_q  <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_kind   = out_kind_q;
	assign m_res    = out_res_q;

	a_colon_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && tok.kind == TK_COLON) |=> (phase_q == PH_COUNT && !nib_q && !err_q))
		else $error("colon did not restart the record");

	a_data_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_kind_q == KIND_DATA) |-> (out_res_q.record_status == ST_OK))
		else $error("data beat with non-ok status");

	a_no_pop_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |-> !pop)
		else $error("token taken while result stalled");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (idx_q < count_q))
		else $error("data index past byte count");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit && emit_kind == KIND_END) |=> (phase_q == PH_IDLE))
		else $error("end report without return to idle");

endmodule

FILE: rtl/intel_hex_record_decoder_top.sv
// Top level of the HEX record decoder: classifier, token queue and record parser.
// The character that completes a result passes the classifier register, the token queue
// and the parser's output register before m_tvalid rises.
// Throughput: one character a cycle while the classifier and queue can accept it; the parser
// takes one queued token each cycle that its output register is free or being drained.
// Reset: arst_n clears the parser to idle, the queue to empty and the address registers to 0.
// Depends on ihex_pkg, ihex_front, ihex_queue and ihex_back.

module intel_hex_record_decoder_top #(
	parameter int QUEUE_DEPTH = ihex_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] char_code
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // data_byte, byte_offset, record_status, type_code,
	                                // byte_count, record_address, upper_linear,
	                                // segment_base, start_address; [127:122] zero
	output logic         m_tuser    // [0] result_kind
);
	import ihex_pkg::*;

	logic    f_valid;
	logic    f_ready;
	tok_t    f_tok;
	logic    q_valid;
	logic    q_ready;
	tok_t    q_tok;
	result_t res;

	ihex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	ihex_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_tok   (f_tok),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_tok   (q_tok)
	);

	ihex_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok_ready (q_ready),
		.tok       (q_tok),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_kind    (m_tuser),
		.m_res     (res)
	);

	assign m_tdata = {6'd0, res.start_address, res.segment_base, res.upper_linear,
		res.record_address, res.byte_count, res.type_code, res.record_status,
		res.byte_offset, res.data_byte};

endmodule

FILE: verif/intel_hex_record_decoder_top_tb.sv
// Testbench for intel_hex_record_decoder_top: streams HEX text into the decoder and checks
// every result beat against an in-bench record decoder, under four idling regimes.
// Depends on ihex_pkg and the RTL under rtl.
`timescale 1ns / 1ps

module intel_hex_record_decoder_top_tb;
	import ihex_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_CHARS = 200;
	localparam int PRINT_LIMIT = 50;
	localparam logic [7:0] REC_EOF = 8'h01;
	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam int CASE_UPPER = 0;
	localparam int CASE_LOWER = 1;
	localparam int CASE_MIXED = 2;

	typedef struct packed {
		logic    kind;
		result_t f;
	} out_beat_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic [7:0]   s_tdata  = 8'h00;
	logic         s_tready;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic         m_tuser;

	intel_hex_record_decoder_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	logic [7:0] text_q[$];
	logic [7:0] rec_bytes[$];
	out_beat_t  decoded_q[$];

	int gap_pct[4]  = '{0, 55, 0, 24};
	int hold_pct[4] = '{0, 0, 55, 24};
	int send_gap_pct = 0;
	int stall_pct    = 0;
	int chars_queued = 0;
	int chars_taken  = 0;
	int record_chars = 0;
	int errors       = 0;
	int data_seen    = 0;
	int ends_seen[4] = '{default: 0};
	int quiet        = 0;

	// decoder state
	phase_t      ph        = PH_IDLE;
	logic [3:0]  hi_nib    = '0;
	logic        nib_wait  = 1'b0;
	logic [7:0]  rec_count = '0;
	logic [7:0]  rec_index = '0;
	logic [15:0] rec_addr  = '0;
	logic [7:0]  rec_type  = '0;
	logic [7:0]  rec_sum   = '0;
	logic [31:0] shift_val = '0;
	logic        bad_seen  = 1'b0;
	logic [15:0] ula_reg   = '0;
	logic [15:0] seg_reg   = '0;
	logic [31:0] start_reg = '0;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n, input int case_mode);
		logic lower;
		lower = (case_mode == CASE_LOWER) ||
			(case_mode == CASE_MIXED && $urandom_range(1) == 1);
		if (n < 4'd10)
			return "0" + n;
		return (lower ? "a" : "A") + n - 8'd10;
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (is_hex(c) || c == CHAR_COLON);
		return c;
	endfunction

	function automatic out_beat_t make_beat(input logic kind, input logic [7:0] d,
			input logic [15:0] ofs, input logic [1:0] status);
		out_beat_t e;
		e.kind = kind;
		e.f.data_byte = d;
		e.f.byte_offset = ofs;
		e.f.record_status = status;
		e.f.type_code = rec_type;
		e.f.byte_count = rec_count;
		e.f.record_address = rec_addr;
		e.f.upper_linear = ula_reg;
		e.f.segment_base = seg_reg;
		e.f.start_address = start_reg;
		return e;
	endfunction

	task automatic put_char(input logic [7:0] c);
		text_q.push_back(c);
		chars_queued++;
	endtask

	task automatic begin_record(input logic [7:0] cnt, input logic [15:0] addr,
			input logic [7:0] typ);
		rec_bytes.delete();
		rec_bytes.push_back(cnt);
		rec_bytes.push_back(addr[15:8]);
		rec_bytes.push_back(addr[7:0]);
		rec_bytes.push_back(typ);
	endtask

	// big-endian, n bytes from the low end of v
	task automatic add_data(input logic [31:0] v, input int n);
		int k;
		for (k = n - 1; k >= 0; k--)
			rec_bytes.push_back(v[8 * k +: 8]);
	endtask

	task automatic seal_record(input logic good);
		logic [7:0] sum;
		logic [7:0] chk;
		sum = '0;
		foreach (rec_bytes[k])
			sum = sum + rec_bytes[k];
		chk = 8'h00 - sum;
		if (!good)
			chk = chk + 8'($urandom_range(1, 255));
		rec_bytes.push_back(chk);
	endtask

	// bad_at puts a junk character ahead of that digit; cut_at drops the digits from there on
	task automatic emit_record(input int bad_at, input int cut_at, input int case_mode);
		int i;
		int n;
		logic [7:0] b8;
		n = 2 * rec_bytes.size();
		put_char(CHAR_COLON);
		for (i = 0; i < n && i != cut_at; i++) begin
			if (i == bad_at)
				put_char(junk_char());
			b8 = rec_bytes[i / 2];
			put_char(hex_digit((i % 2 == 0) ? b8[7:4] : b8[3:0], case_mode));
		end
		record_chars += i + 1;
	endtask

	task automatic decode_char(input logic [7:0] c);
		logic [7:0] v;
		logic [7:0] b8;
		logic [1:0] status;
		if (c == CHAR_COLON) begin
			ph = PH_COUNT;
			hi_nib = '0;
			nib_wait = 1'b0;
			rec_count = '0;
			rec_index = '0;
			rec_addr = '0;
			rec_type = '0;
			rec_sum = '0;
			shift_val = '0;
			bad_seen = 1'b0;
		end else if (ph != PH_IDLE) begin
			if (!is_hex(c)) begin
				bad_seen = 1'b1;
			end else begin
				if (c <= "9")
					v = c - "0";
				else if (c <= "F")
					v = c - "A" + 8'd10;
				else
					v = c - "a" + 8'd10;
				if (!nib_wait) begin
					hi_nib = v[3:0];
					nib_wait = 1'b1;
				end else begin
					nib_wait = 1'b0;
					b8 = {hi_nib, v[3:0]};
					rec_sum = rec_sum + b8;
					case (ph)
						PH_COUNT: begin
							rec_count = b8;
							rec_index = '0;
							ph = PH_ADDR;
						end
						PH_ADDR: begin
							rec_addr = {rec_addr[7:0], b8};
							rec_index = rec_index + 8'd1;
							if (rec_index >= 8'd2) begin
								rec_index = '0;
								ph = PH_TYPE;
							end
						end
						PH_TYPE: begin
							rec_type = b8;
							rec_index = '0;
							ph = (rec_count != 8'd0) ? PH_DATA : PH_CHECK;
						end
						PH_DATA: begin
							shift_val = {shift_val[23:0], b8};
							if (rec_type == REC_DATA)
								decoded_q.push_back(make_beat(KIND_DATA, b8,
									rec_addr + {8'h00, rec_index}, ST_OK));
							rec_index = rec_index + 8'd1;
							if (rec_index >= rec_count)
								ph = PH_CHECK;
						end
						PH_CHECK: begin
							if (bad_seen)
								status = ST_BAD_CHAR;
							else if (rec_sum != 8'd0)
								status = ST_CHECKSUM;
							else if (rec_type > REC_SLA)
								status = ST_BAD_TYPE;
							else
								status = ST_OK;
							if (status == ST_OK) begin
								case (rec_type)
									REC_ESA: seg_reg = shift_val[15:0];
									REC_ELA: ula_reg = shift_val[15:0];
									REC_SSA, REC_SLA: start_reg = shift_val;
									default: ;
								endcase
							end
							decoded_q.push_back(make_beat(KIND_END, 8'h00, 16'h0000, status));
							ph = PH_IDLE;
						end
						default: ph = PH_IDLE;
					endcase
				end
			end
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("%0t %s: expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	// sender: one character per beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_char(s_tdata);
				chars_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (text_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					s_tdata <= text_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		out_beat_t want;
		result_t   got;
		if (arst_n && m_tvalid && m_tready) begin
			got.data_byte = m_tdata[7:0];
			got.byte_offset = m_tdata[23:8];
			got.record_status = m_tdata[25:24];
			got.type_code = m_tdata[33:26];
			got.byte_count = m_tdata[41:34];
			got.record_address = m_tdata[57:42];
			got.upper_linear = m_tdata[73:58];
			got.segment_base = m_tdata[89:74];
			got.start_address = m_tdata[121:90];
			if (decoded_q.size() == 0) begin
				errors++;
				if (errors <= PRINT_LIMIT)
					$display("%0t result beat with nothing expected: %s %0b tdata %h",
						$time, "expected none, actual kind", m_tuser, m_tdata);
			end else begin
				want = decoded_q.pop_front();
				check_field("result_kind", 32'(want.kind), 32'(m_tuser));
				check_field("data_byte", 32'(want.f.data_byte), 32'(got.data_byte));
				check_field("byte_offset", 32'(want.f.byte_offset), 32'(got.byte_offset));
				check_field("record_status", 32'(want.f.record_status),
					32'(got.record_status));
				check_field("type_code", 32'(want.f.type_code), 32'(got.type_code));
				check_field("byte_count", 32'(want.f.byte_count), 32'(got.byte_count));
				check_field("record_address", 32'(want.f.record_address),
					32'(got.record_address));
				check_field("upper_linear", 32'(want.f.upper_linear),
					32'(got.upper_linear));
				check_field("segment_base", 32'(want.f.segment_base),
					32'(got.segment_base));
				check_field("start_address", want.f.start_address, got.start_address);
				check_field("tdata padding", 32'd0, 32'(m_tdata[127:122]));
				if (want.kind == KIND_END)
					ends_seen[want.f.record_status]++;
				else
					data_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t no beat for %0d cycles, %0d results outstanding",
					$time, quiet, decoded_q.size());
				$display("intel_hex_record_decoder_top: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int mode;
		int pick;
		int cnt;
		int nd;
		int bad_at;
		int cut_at;
		logic [7:0] typ;

		// stray text ahead of any record
		put_char(8'h00);
		put_char(8'hff);
		put_char("4");
		put_char("G");
		put_char(CHAR_CR);
		put_char(CHAR_LF);
		begin_record(8'd2, 16'h0100, REC_DATA);
		add_data(32'h00ff, 2);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		put_char(CHAR_CR);
		put_char(CHAR_LF);
		// offset wraps past ffff
		begin_record(8'd3, 16'hffff, REC_DATA);
		add_data(32'ha55ac3, 3);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_LOWER);
		begin_record(8'd0, 16'h0000, REC_DATA);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		begin_record(8'd2, 16'h0000, REC_ELA);
		add_data(32'h1234, 2);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_MIXED);
		begin_record(8'd2, 16'h0000, REC_ESA);
		add_data(32'hf000, 2);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		begin_record(8'd4, 16'h0000, REC_SSA);
		add_data(32'h12345678, 4);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_LOWER);
		begin_record(8'd4, 16'h0000, REC_SLA);
		add_data(32'h80000001, 4);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		// wrong checksum, register must hold
		begin_record(8'd2, 16'h0000, REC_ELA);
		add_data(32'hffff, 2);
		seal_record(1'b0);
		emit_record(-1, -1, CASE_UPPER);
		// odd counts on address records
		begin_record(8'd1, 16'h0000, REC_ELA);
		add_data(32'h5a, 1);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		begin_record(8'd3, 16'h0000, REC_ESA);
		add_data(32'h112233, 3);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		begin_record(8'd6, 16'h0000, REC_SLA);
		add_data(32'h0102, 2);
		add_data(32'h03040506, 4);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		begin_record(8'd1, 16'h0000, REC_SSA);
		add_data(32'h99, 1);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		begin_record(8'd0, 16'h0000, REC_EOF);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		// unknown types
		begin_record(8'd0, 16'h0000, 8'h06);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		begin_record(8'd2, 16'h4321, 8'hff);
		add_data(32'haabb, 2);
		seal_record(1'b1);
		emit_record(-1, -1, CASE_UPPER);
		// junk in the data field
		begin_record(8'd2, 16'h2000, REC_DATA);
		add_data(32'h1122, 2);
		seal_record(1'b1);
		emit_record(9, -1, CASE_UPPER);
		// junk and bad checksum together
		begin_record(8'd2, 16'h0000, REC_ELA);
		add_data(32'h7788, 2);
		seal_record(1'b0);
		emit_record(0, -1, CASE_UPPER);
		// bad checksum on an unknown type
		begin_record(8'd0, 16'h0000, 8'h80);
		seal_record(1'b0);
		emit_record(-1, -1, CASE_UPPER);
		// colon mid record, next record follows at once
		begin_record(8'd4, 16'h3000, REC_DATA);
		add_data(32'hdeadbeef, 4);
		seal_record(1'b1);
		emit_record(-1, 11, CASE_UPPER);
		// junk between the two digits of a byte
		begin_record(8'd1, 16'h0000, REC_DATA);
		add_data(32'h42, 1);
		seal_record(1'b1);
		emit_record(1, -1, CASE_UPPER);
		begin_record(8'd255, 16'hff80, REC_DATA);
		repeat (255)
			rec_bytes.push_back(8'($urandom_range(255)));
		seal_record(1'b1);
		emit_record(-1, -1, CASE_MIXED);
		put_char(CHAR_CR);
		put_char(CHAR_LF);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (mode = 0; mode < 4; mode++) begin
			while (text_q.size() != 0)
				@(negedge clk);
			send_gap_pct = gap_pct[mode];
			stall_pct = hold_pct[mode];
			record_chars = 0;
			while (record_chars < PHASE_CHARS) begin
				pick = $urandom_range(99);
				if (pick < 50)
					typ = REC_DATA;
				else if (pick < 58)
					typ = REC_EOF;
				else if (pick < 64)
					typ = REC_ESA;
				else if (pick < 70)
					typ = REC_SSA;
				else if (pick < 78)
					typ = REC_ELA;
				else if (pick < 84)
					typ = REC_SLA;
				else
					typ = 8'($urandom_range(255));
				if (typ == REC_ESA || typ == REC_ELA)
					cnt = 2;
				else if (typ == REC_SSA || typ == REC_SLA)
					cnt = 4;
				else if (typ == REC_EOF)
					cnt = 0;
				else
					cnt = $urandom_range(16);
				if ($urandom_range(7) == 0)
					cnt = $urandom_range(20);
				begin_record(8'(cnt), 16'($urandom_range(65535)), typ);
				repeat (cnt)
					rec_bytes.push_back(8'($urandom_range(255)));
				seal_record($urandom_range(99) < 85);
				nd = 2 * rec_bytes.size();
				bad_at = ($urandom_range(99) < 8) ? int'($urandom_range(nd - 1)) : -1;
				cut_at = ($urandom_range(99) < 5) ? int'($urandom_range(nd - 1)) : -1;
				emit_record(bad_at, cut_at, $urandom_range(2));
				pick = $urandom_range(99);
				if (pick < 50) begin
					put_char(CHAR_CR);
					put_char(CHAR_LF);
				end else if (pick >= 80) begin
					repeat ($urandom_range(1, 4))
						put_char(8'($urandom_range(255)));
				end
			end
		end

		while (chars_taken != chars_queued || decoded_q.size() != 0)
			@(negedge clk);
		repeat (8)
			@(negedge clk);

		$display("%0d characters sent over four idling regimes; %0d data beats checked",
			chars_taken, data_seen);
		$display("record reports: %0d ok, %0d checksum, %0d bad character, %0d bad type",
			ends_seen[ST_OK], ends_seen[ST_CHECKSUM], ends_seen[ST_BAD_CHAR],
			ends_seen[ST_BAD_TYPE]);
		if (errors == 0)
			$display("intel_hex_record_decoder_top: match");
		else
			$display("intel_hex_record_decoder_top: mismatch");
		$finish;
	end

endmodule
